### src/vao_pkg.sv
// ----------------------------------------------------------------------------
// vao_pkg
// Shared types and constants of the voice allocator with oldest stealing.
// ----------------------------------------------------------------------------
package vao_pkg;

  // Default size of the voice pool.
  localparam int unsigned NumVoicesDef = 32;

  localparam int unsigned IdW    = 32;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned StampW = 32;
  localparam int unsigned IdxW   = 5;

  // Command codes carried in the cmd field. The unused code acts as a query.
  typedef enum logic [1:0] {
    CMD_ASSIGN = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  // One request item.
  typedef struct packed {
    logic [1:0]       cmd;
    logic [IdW-1:0]   owner_id;
    logic [ChanW-1:0] owner_channel;
    logic [IdxW-1:0]  voice_index;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [IdxW-1:0]  granted_index;
    logic             stolen;
    logic [IdW-1:0]   holder_id;
    logic [ChanW-1:0] holder_channel;
    logic             is_free;
    logic             bad_index;
  } rsp_t;

  // One entry of the voice table.
  typedef struct packed {
    logic              free;
    logic [IdW-1:0]    id;
    logic [ChanW-1:0]  chan;
    logic [StampW-1:0] stamp;
  } entry_t;

  // Value of an entry that was never written since reset.
  localparam entry_t EntryReset = '{free: 1'b1, id: '0, chan: '0, stamp: '0};

endpackage

### src/vao_ram.sv
// ----------------------------------------------------------------------------
// vao_ram
// Voice table: one write port, one registered read port. A valid bit per
// entry makes entries that were never written read as the reset entry.
// ----------------------------------------------------------------------------
module vao_ram #(
  parameter int unsigned Depth = vao_pkg::NumVoicesDef,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  vao_pkg::entry_t     wr_data_i,
  input  logic                rd_en_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  output vao_pkg::entry_t     rd_data_o
);

  vao_pkg::entry_t mem [Depth];
  logic [Depth-1:0] valid_q;
  vao_pkg::entry_t  data_q;
  logic             vld_q;

  // Valid bits are cleared by reset and set by the first write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  // Storage array with a registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      data_q <= mem[rd_addr_i];
    end
  end

  // Entries never written read as the reset entry.
  assign rd_data_o = vld_q ? data_q : vao_pkg::EntryReset;

endmodule

### src/voice_allocator_oldest_steal.sv
// ----------------------------------------------------------------------------
// voice_allocator_oldest_steal
// Voice allocator that hands out free voices and steals the oldest one.
// ----------------------------------------------------------------------------
// Timing: an item is taken when start is high and busy is low, and its result
// shows on rsp_o for one cycle with done_o high; the receiver cannot stall.
// A free or query item keeps busy high for one cycle, in which the table entry
// is read and then written back or answered, and its result is registered at
// the end of that cycle; a free or query with an index not below NumVoices
// answers in the next cycle without touching the table and never raises busy.
// An assign reads the table one entry per cycle from index 0 and stops at the
// first free entry; when the pool is full it steals the oldest entry after
// reading the last one. The single read port of the voice table sets this
// rate. The result appears in the first cycle in which busy is low again; the
// next item may be started in that same cycle. No clearing pass is needed
// after reset.
module voice_allocator_oldest_steal #(
  parameter int unsigned NumVoices = vao_pkg::NumVoicesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  vao_pkg::req_t req_i,
  output logic          done_o,
  output vao_pkg::rsp_t rsp_o
);

  localparam int unsigned AddrW = (NumVoices > 1) ? $clog2(NumVoices) : 1;
  localparam logic [AddrW-1:0] LastIdx = AddrW'(NumVoices - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ
  } state_e;

  state_e                         state_q, state_d;
  vao_pkg::req_t                  req_q, req_d;
  logic [AddrW-1:0]               idx_q, idx_d;
  logic [AddrW-1:0]               pick_q, pick_d;
  logic [vao_pkg::StampW-1:0]     oldest_q, oldest_d;
  logic [vao_pkg::StampW-1:0]     stamp_q, stamp_d;
  logic                           done_q, done_d;
  vao_pkg::rsp_t                  rsp_q, rsp_d;

  logic                           wr_en;
  logic [AddrW-1:0]               wr_addr;
  vao_pkg::entry_t                wr_data;
  logic                           rd_en;
  logic [AddrW-1:0]               rd_addr;
  vao_pkg::entry_t                rd_data;

  logic                           accept;
  logic                           req_bad;
  logic [AddrW-1:0]               req_addr;
  logic                           is_last;
  logic [AddrW-1:0]               cand_idx;
  logic [vao_pkg::StampW-1:0]     cand_stamp;

  vao_ram #(
    .Depth (NumVoices),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Index checks on the incoming item.
  assign req_bad  = (32'(req_i.voice_index) >= 32'(NumVoices));
  assign req_addr = AddrW'(req_i.voice_index);

  // Oldest-entry tracking during the scan: entry 0 seeds it, later entries
  // replace it only with a strictly smaller stamp.
  assign is_last = (idx_q == LastIdx);
  always_comb begin
    if ((idx_q == '0) || (rd_data.stamp < oldest_q)) begin
      cand_idx   = idx_q;
      cand_stamp = rd_data.stamp;
    end else begin
      cand_idx   = pick_q;
      cand_stamp = oldest_q;
    end
  end

  // Sequencer: table reads, write-back and result formation.
  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    idx_d    = idx_q;
    pick_d   = pick_q;
    oldest_d = oldest_q;
    stamp_d  = stamp_q;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    wr_en    = 1'b0;
    wr_addr  = idx_q;
    wr_data  = vao_pkg::EntryReset;
    rd_en    = 1'b0;
    rd_addr  = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d = req_i;
          if (req_i.cmd == vao_pkg::CMD_ASSIGN) begin
            rd_en   = 1'b1;
            rd_addr = '0;
            idx_d   = '0;
            state_d = ST_SCAN;
          end else if (req_bad) begin
            done_d = 1'b1;
            rsp_d  = '{granted_index: req_i.voice_index, stolen: 1'b0,
                       holder_id: '0, holder_channel: '0,
                       is_free: 1'b0, bad_index: 1'b1};
          end else begin
            rd_en   = 1'b1;
            rd_addr = req_addr;
            idx_d   = req_addr;
            state_d = ST_READ;
          end
        end
      end

      ST_SCAN: begin
        if (rd_data.free || is_last) begin
          // Claim the first free entry, or steal the oldest one.
          wr_en   = 1'b1;
          wr_addr = rd_data.free ? idx_q : cand_idx;
          stamp_d = stamp_q + 1'b1;
          wr_data = '{free: 1'b0, id: req_q.owner_id,
                      chan: req_q.owner_channel, stamp: stamp_d};
          done_d  = 1'b1;
          rsp_d   = '{granted_index: vao_pkg::IdxW'(wr_addr),
                      stolen: !rd_data.free,
                      holder_id: req_q.owner_id,
                      holder_channel: req_q.owner_channel,
                      is_free: 1'b0, bad_index: 1'b0};
          state_d = ST_IDLE;
        end else begin
          pick_d   = cand_idx;
          oldest_d = cand_stamp;
          rd_en    = 1'b1;
          rd_addr  = idx_q + 1'b1;
          idx_d    = idx_q + 1'b1;
        end
      end

      ST_READ: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
        if (req_q.cmd == vao_pkg::CMD_FREE) begin
          // Release the owner but keep the stamp.
          wr_en   = 1'b1;
          wr_addr = idx_q;
          wr_data = '{free: 1'b1, id: '0, chan: '0, stamp: rd_data.stamp};
          rsp_d   = '{granted_index: req_q.voice_index, stolen: 1'b0,
                      holder_id: '0, holder_channel: '0,
                      is_free: 1'b1, bad_index: 1'b0};
        end else begin
          rsp_d   = '{granted_index: req_q.voice_index, stolen: 1'b0,
                      holder_id: rd_data.id, holder_channel: rd_data.chan,
                      is_free: rd_data.free, bad_index: 1'b0};
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      req_q    <= '0;
      idx_q    <= '0;
      pick_q   <= '0;
      oldest_q <= '0;
      stamp_q  <= '0;
      done_q   <= 1'b0;
      rsp_q    <= '0;
    end else begin
      state_q  <= state_d;
      req_q    <= req_d;
      idx_q    <= idx_d;
      pick_q   <= pick_d;
      oldest_q <= oldest_d;
      stamp_q  <= stamp_d;
      done_q   <= done_d;
      rsp_q    <= rsp_d;
    end
  end

  // A result always follows an accepted item or work in progress.
  a_done_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy || start))
    else $error("result without a pending item");

  // The stamp counter moves only when an entry is claimed.
  a_stamp_on_claim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stamp_q != $past(stamp_q)) |-> $past(wr_en && !wr_data.free))
    else $error("stamp counter changed without a claim");

  // A rejected index never reports a steal or a free entry.
  a_bad_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.bad_index) |-> (!rsp_o.stolen && !rsp_o.is_free))
    else $error("bad index result carries flags");

  // The table is never written while the block is idle.
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !wr_en)
    else $error("table written while idle");

endmodule
